// ===== design/scn_pkg.sv =====
// ----------------------------------------------------------------------------
// scn_pkg: shared types and constants for the strided channel normalizer
// Field widths, register indexes, and the request record passed from the
// front end to the back end.
// ----------------------------------------------------------------------------
package scn_pkg;

   localparam int MAX_DIMS_DEF     = 4;
   localparam int MAX_CHANNELS_DEF = 16;
   localparam int DIM_WIDTH_DEF    = 16;

   localparam int SAMPLE_W = 16;
   localparam int MEAN_W   = 24;
   localparam int STD_W    = 16;
   localparam int CHAN_W   = 4;
   localparam int OUT_W    = 24;
   localparam int OFS_W    = 34;
   localparam int PACK_W   = 16;
   localparam int PACK_N   = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;

   // numerator (sample*256 - mean)*256 fits in 41 bits signed
   localparam int NUM_W = 41;
   localparam int QUO_W = NUM_W;

   localparam logic [CSR_IDX_W-1:0] REG_NORM_AXIS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DIM_COUNT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DIM_SIZES   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STRIDE_LIST = 2'd3;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   localparam logic [CSR_DATA_W-1:0] DIM_SIZES_RST = 64'h0001_0001_0001_0001;
   localparam logic [STD_W-1:0]      STD_RST       = 16'd256;

   // front-to-back request: one sample job
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic signed [MEAN_W-1:0]   mean;
      logic [STD_W-1:0]           std;
      logic [OFS_W-1:0]           offset;
      logic [CHAN_W-1:0]          channel;
      logic                       tensor_end;
   } job_type;

endpackage

// ===== design/strided_channel_normalizer.sv =====
// A sample request passes the front job register, the 41-step bit-serial
// divider and the result register before it shows on rsp_ ports. A new
// sample is taken only once the divider is idle; a held response stalls
// input only once a second result is ready. Loads and samples go one at a time.
// Synchronous active-high reset restores registers, clears the position
// counter, and resets every channel to mean 0, std 1.0; no clearing pass.
// ----------------------------------------------------------------------------
// strided_channel_normalizer: per-channel mean/std normalizer, strided walk
// Front end walks positions and looks up tables; back end divides.
// ----------------------------------------------------------------------------
module strided_channel_normalizer
   import scn_pkg::*;
#(
   parameter int MAX_DIMS     = MAX_DIMS_DEF,
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
   parameter int DIM_WIDTH    = DIM_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   output logic                       full,
   input  logic                       req_command,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic [CHAN_W-1:0]          req_table_channel,
   input  logic signed [MEAN_W-1:0]   req_mean_value,
   input  logic [STD_W-1:0]           req_std_value,
   output logic                       empty,
   input  logic                       pop,
   output logic signed [OUT_W-1:0]    rsp_normalized_value,
   output logic [OFS_W-1:0]           rsp_source_offset,
   output logic [CHAN_W-1:0]          rsp_channel_used,
   output logic                       rsp_tensor_end,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data
);

   logic [1:0]            norm_axis_ff;
   logic [2:0]            dim_count_ff;
   logic [CSR_DATA_W-1:0] dim_sizes_ff;
   logic [CSR_DATA_W-1:0] stride_list_ff;
   logic                  take;
   logic                  job_valid;
   logic                  busy;
   logic                  rsp_valid;
   job_type               job;

   // one sample in flight at a time
   assign full      = job_valid || busy;
   assign take      = push && !full;
   assign empty     = !rsp_valid;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         norm_axis_ff   <= '0;
         dim_count_ff   <= 3'd4;
         dim_sizes_ff   <= DIM_SIZES_RST;
         stride_list_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_NORM_AXIS:   norm_axis_ff   <= csr_data[1:0];
            REG_DIM_COUNT:   dim_count_ff   <= csr_data[2:0];
            REG_DIM_SIZES:   dim_sizes_ff   <= csr_data;
            REG_STRIDE_LIST: stride_list_ff <= csr_data;
            default: ;
         endcase
      end
   end

   scn_front #(.MAX_DIMS(MAX_DIMS), .MAX_CHANNELS(MAX_CHANNELS), .DIM_WIDTH(DIM_WIDTH))
   u_front (
      .clock, .reset, .take,
      .command(req_command), .sample(req_sample), .table_channel(req_table_channel),
      .mean_value(req_mean_value), .std_value(req_std_value),
      .norm_axis(norm_axis_ff), .dim_count(dim_count_ff),
      .dim_sizes(dim_sizes_ff), .stride_list(stride_list_ff),
      .job_valid, .job
   );

   scn_back u_back (
      .clock, .reset, .job_valid, .job, .busy, .rsp_valid,
      .rsp_take(pop),
      .normalized_value(rsp_normalized_value),
      .source_offset(rsp_source_offset),
      .channel_used(rsp_channel_used),
      .tensor_end(rsp_tensor_end)
   );

endmodule

// ===== design/scn_front.sv =====
// ----------------------------------------------------------------------------
// scn_front: position counter, channel tables and job builder
// Accepts requests, applies table loads, and for samples looks up the
// channel entry, forms the source offset and advances the digits.
// ----------------------------------------------------------------------------
module scn_front
   import scn_pkg::*;
#(
   parameter int MAX_DIMS     = MAX_DIMS_DEF,
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
   parameter int DIM_WIDTH    = DIM_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       take,
   input  logic                       command,
   input  logic signed [SAMPLE_W-1:0] sample,
   input  logic [CHAN_W-1:0]          table_channel,
   input  logic signed [MEAN_W-1:0]   mean_value,
   input  logic [STD_W-1:0]           std_value,
   input  logic [1:0]                 norm_axis,
   input  logic [2:0]                 dim_count,
   input  logic [CSR_DATA_W-1:0]      dim_sizes,
   input  logic [CSR_DATA_W-1:0]      stride_list,
   output logic                       job_valid,
   output job_type                    job
);

   localparam int CH_IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   logic [DIM_WIDTH-1:0]      digit_ff [MAX_DIMS];
   logic [DIM_WIDTH-1:0]      digit_in [MAX_DIMS];
   logic signed [MEAN_W-1:0]  mean_ff  [MAX_CHANNELS];
   logic [STD_W-1:0]          std_ff   [MAX_CHANNELS];

   logic [3:0]        used_n;
   logic [OFS_W-1:0]  offset;
   logic [CHAN_W-1:0] chan;
   logic [CH_IDX_W-1:0] chan_idx;
   logic              carry_out;

   // effective dimension count
   always_comb begin
      if (dim_count == 3'd0) used_n = 4'd1;
      else if (32'(dim_count) > MAX_DIMS) used_n = 4'(MAX_DIMS);
      else used_n = {1'b0, dim_count};
   end

   // offset, channel, and counter advance (last used dim fastest)
   always_comb begin
      logic              carry;
      logic [DIM_WIDTH:0] nxt;
      logic [DIM_WIDTH-1:0] sz;
      logic [PACK_W-1:0] stv;
      offset = '0;
      chan = '0;
      carry = 1'b1;
      for (int d = 0; d < MAX_DIMS; d++) begin
         digit_in[d] = digit_ff[d];
      end
      for (int d = 0; d < MAX_DIMS; d++) begin
         if (d < PACK_N) stv = stride_list[d*PACK_W +: PACK_W];
         else stv = '0;
         if (4'(d) < used_n) begin
            offset = offset + OFS_W'(digit_ff[d]) * OFS_W'(stv);
            if (2'(d) == norm_axis && d < 4) begin
               if (32'(digit_ff[d]) >= MAX_CHANNELS) chan = CHAN_W'(MAX_CHANNELS - 1);
               else chan = CHAN_W'(digit_ff[d]);
            end
         end
      end
      for (int d = MAX_DIMS - 1; d >= 0; d--) begin
         if (d < PACK_N) sz = DIM_WIDTH'(dim_sizes[d*PACK_W +: PACK_W]);
         else sz = DIM_WIDTH'(1);
         if (sz == '0) sz = DIM_WIDTH'(1);
         nxt = {1'b0, digit_ff[d]} + 1'b1;
         if (4'(d) < used_n && carry) begin
            if (nxt >= {1'b0, sz}) digit_in[d] = '0;
            else begin
               digit_in[d] = nxt[DIM_WIDTH-1:0];
               carry = 1'b0;
            end
         end
      end
      carry_out = carry;
   end

   assign chan_idx = CH_IDX_W'(chan);

   // tables, counter and job register
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < MAX_DIMS; d++) digit_ff[d] <= '0;
         for (int c = 0; c < MAX_CHANNELS; c++) begin
            mean_ff[c] <= '0;
            std_ff[c]  <= STD_RST;
         end
         job_valid <= 1'b0;
      end else begin
         job_valid <= take && command == CMD_SAMPLE;
         if (take && command == CMD_LOAD) begin
            if (32'(table_channel) < MAX_CHANNELS) begin
               mean_ff[CH_IDX_W'(table_channel)] <= mean_value;
               std_ff[CH_IDX_W'(table_channel)]  <= std_value;
            end
         end
         if (take && command == CMD_SAMPLE) begin
            for (int d = 0; d < MAX_DIMS; d++) digit_ff[d] <= digit_in[d];
         end
      end
      job.sample     <= sample;
      job.mean       <= mean_ff[chan_idx];
      job.std        <= std_ff[chan_idx];
      job.offset     <= offset;
      job.channel    <= chan;
      job.tensor_end <= carry_out;
   end

endmodule

// ===== design/scn_back.sv =====
// ----------------------------------------------------------------------------
// scn_back: fixed point normalize unit
// Restoring divider, one quotient bit per cycle, then truncate toward zero
// and saturate to 24 bits. A result register holds the response until
// popped, so the divider is free for the next job meanwhile.
// ----------------------------------------------------------------------------
module scn_back
   import scn_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     job_valid,
   input  job_type                  job,
   output logic                     busy,
   output logic                     rsp_valid,
   input  logic                     rsp_take,
   output logic signed [OUT_W-1:0]  normalized_value,
   output logic [OFS_W-1:0]         source_offset,
   output logic [CHAN_W-1:0]        channel_used,
   output logic                     tensor_end
);

   typedef enum logic [1:0] {IDLE, DIVIDE, FINISH} state_type;

   localparam int CNT_W = $clog2(QUO_W + 1);
   localparam logic signed [QUO_W-1:0] POS_MAX = QUO_W'(24'sh7FFFFF);
   localparam logic signed [QUO_W-1:0] NEG_MIN = -QUO_W'(25'sh0800000);

   state_type           state_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [QUO_W-1:0]    quo_ff;
   logic [STD_W:0]      rem_ff;
   logic [STD_W-1:0]    std_ff;
   logic                neg_ff;
   logic                zero_ff;
   logic [OFS_W-1:0]    ofs_ff;
   logic [CHAN_W-1:0]   chan_ff;
   logic                end_ff;
   logic                out_valid_ff;
   logic                out_free;
   logic signed [NUM_W-1:0] num;
   logic [NUM_W-1:0]    mag;
   logic [STD_W:0]      trial;
   logic signed [QUO_W-1:0] sq;

   assign num = (NUM_W'(job.sample) * 65536) - (NUM_W'(job.mean) * 256);
   assign mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
   assign trial = {rem_ff[STD_W-1:0], quo_ff[QUO_W-1]};
   assign sq = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

   // result register can take a new value when empty or being popped
   assign out_free  = !out_valid_ff || rsp_take;
   assign busy      = state_ff != IDLE;
   assign rsp_valid = out_valid_ff;

   // divide sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            IDLE: if (job_valid) begin
               state_ff <= DIVIDE;
               count_ff <= CNT_W'(QUO_W);
               quo_ff   <= mag;
               rem_ff   <= '0;
               std_ff   <= job.std;
               neg_ff   <= num[NUM_W-1];
               zero_ff  <= num == '0;
               ofs_ff   <= job.offset;
               chan_ff  <= job.channel;
               end_ff   <= job.tensor_end;
            end
            DIVIDE: begin
               if (trial >= {1'b0, std_ff}) begin
                  rem_ff <= trial - {1'b0, std_ff};
                  quo_ff <= {quo_ff[QUO_W-2:0], 1'b1};
               end else begin
                  rem_ff <= trial;
                  quo_ff <= {quo_ff[QUO_W-2:0], 1'b0};
               end
               count_ff <= count_ff - 1'b1;
               if (count_ff == CNT_W'(1)) state_ff <= FINISH;
            end
            FINISH: if (out_free) begin
               if (std_ff == '0) begin
                  if (zero_ff) normalized_value <= '0;
                  else if (neg_ff) normalized_value <= 24'sh800000;
                  else normalized_value <= 24'sh7FFFFF;
               end else if (sq > POS_MAX) normalized_value <= 24'sh7FFFFF;
               else if (sq < NEG_MIN) normalized_value <= 24'sh800000;
               else normalized_value <= sq[OUT_W-1:0];
               source_offset <= ofs_ff;
               channel_used  <= chan_ff;
               tensor_end    <= end_ff;
               state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
         if (state_ff == FINISH && out_free) out_valid_ff <= 1'b1;
         else if (rsp_take) out_valid_ff <= 1'b0;
      end
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      busy |-> !job_valid) else $error("job arrived while back end busy");
   a_hold_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_take) |=> rsp_valid && $stable(normalized_value))
      else $error("result lost before pop");
   a_finish_to_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == FINISH |=> rsp_valid) else $error("finish did not present result");

endmodule
